### hw/rtl/crc8f_pkg.sv
// Shared types, constants and the CRC-8 byte update for the command packet framer.
// No dependencies; imported by every module of the block.
`default_nettype none

package crc8f_pkg;

    // Port widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 48;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    // Packet layout
    localparam int HDR_BYTES = 12;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] HDR_ID   = 8'h01;

    localparam logic [1:0] MODE_ILLEGAL = 2'd3;

    // Acknowledge mode word flags
    localparam int ACK_PARAM_BIT   = 0;
    localparam int ACK_TIMEOUT_BIT = 2;

    // Result kinds
    localparam logic RK_TX   = 1'b0;
    localparam logic RK_DONE = 1'b1;

    // Completion status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_MODE  = 3'd1;
    localparam logic [2:0] STAT_CRC_ERR   = 3'd2;
    localparam logic [2:0] STAT_PARAM_ERR = 3'd3;
    localparam logic [2:0] STAT_TIMEOUT   = 3'd4;

    // Job classes produced by the front end
    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_BAD_MODE,
        OP_RX_BYTE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        is_write;
        logic [1:0]  addr_mode;
        logic [1:0]  data_mode;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [7:0]  rx_byte;
    } job_t;

    // CRC-8, poly 0x07, MSB first, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[7] ^ data[7-i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/crc8_command_packet_framer_unit.sv
// Top level of the CRC-8 command packet framer: front end, job queue, back end.
// Depends on crc8f_pkg, crc8f_front, crc8f_queue and crc8f_back.
//
// Usage:
//   s_ channel carries one item per transaction: s_tuser=0 issues a bus request
//   (fields in s_tdata), s_tuser=1 delivers one received acknowledge/read byte.
//   m_ channel returns results: m_tuser=0 is one packet byte (m_tlast on the
//   final one), m_tuser=1 is a completion with status and read data.
//   Order: a completion is written to the job queue when its item is accepted, then
//   to the output register; a request's first packet byte follows once the
//   sequencer has popped the request from the queue and holds it.
//   Packets: a read request sends 12 packet bytes and a write request 13, 14 or
//   16, one packet byte per cycle while m_tready does not stall the output, set
//   by the byte sequencer. The two-entry job queue keeps accepting while the
//   sequencer is busy until it fills.
//   Reset (aresetn low, synchronous) empties the queue and output register and
//   returns to idle with no request pending.
//   A stalled m_tready holds the current result; the back end then stops and
//   s_tready drops once the queue is full.
`default_nettype none

module crc8_command_packet_framer_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata from bit 0: is_write, addr_mode[1:0], data_mode[1:0], address[31:0],
    // write_data[31:0], rx_byte[7:0], zero pad to 80 bits
    input  wire logic [crc8f_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: command
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata from bit 0: tx_byte[7:0], status[2:0], read_data[31:0], zero pad to 48
    output logic [crc8f_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tlast: tx_last
    output logic                                 m_tlast,
    // m_tuser: result_kind
    output logic                                 m_tuser
);
    import crc8f_pkg::*;

    logic  q_full;
    logic  push;
    job_t  push_job;
    logic  pop;
    logic  q_valid;
    job_t  q_job;

    crc8f_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    crc8f_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    crc8f_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### hw/rtl/crc8f_front.sv
// Front end: takes input transactions, unpacks tdata and classifies each item.
// Depends on crc8f_pkg; feeds crc8f_queue.
`default_nettype none

module crc8f_front (
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata from bit 0: is_write, addr_mode[1:0], data_mode[1:0], address[31:0],
    // write_data[31:0], rx_byte[7:0], zero pad
    input  wire logic [crc8f_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: command (0 request, 1 received byte)
    input  wire logic                           s_tuser,
    input  wire logic                           q_full,
    output logic                                push,
    output crc8f_pkg::job_t                     push_job
);
    import crc8f_pkg::*;

    logic [1:0] am;
    logic [1:0] dm;

    assign am = s_tdata[2:1];
    assign dm = s_tdata[4:3];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Unpack and classify
    always_comb begin
        push_job.is_write   = s_tdata[0];
        push_job.addr_mode  = am;
        push_job.data_mode  = dm;
        push_job.address    = s_tdata[36:5];
        push_job.write_data = s_tdata[68:37];
        push_job.rx_byte    = s_tdata[76:69];
        if (s_tuser) begin
            push_job.op = OP_RX_BYTE;
        end else if (am == MODE_ILLEGAL || dm == MODE_ILLEGAL) begin
            push_job.op = OP_BAD_MODE;
        end else begin
            push_job.op = OP_REQUEST;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/crc8f_queue.sv
// Short job queue that decouples the front end from the back end.
// Depends on crc8f_pkg.
`default_nettype none

module crc8f_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire crc8f_pkg::job_t push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 q_valid,
    output crc8f_pkg::job_t      q_job
);
    import crc8f_pkg::*;

    job_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic                do_pop;

    assign full    = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_job   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/crc8f_back.sv
// Back end: emits request packets byte by byte, tracks the acknowledge and read
// data, and drives the registered result channel. Depends on crc8f_pkg.
`default_nettype none

module crc8f_back (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            q_valid,
    input  wire crc8f_pkg::job_t                 q_job,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [crc8f_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);
    import crc8f_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_SEND
    } state_t;

    state_t            state_reg,    state_next;
    logic              pending_reg,  pending_next;
    logic              is_read_reg,  is_read_next;
    logic [1:0]        size_reg,     size_next;
    logic [CNT_W-1:0]  rx_count_reg, rx_count_next;
    logic [7:0]        rx_crc_reg,   rx_crc_next;
    logic [15:0]       ack_mode_reg, ack_mode_next;
    logic [31:0]       read_asm_reg, read_asm_next;
    job_t              req_reg,      req_next;
    logic [IDX_W-1:0]  idx_reg,      idx_next;
    logic [7:0]        tx_crc_reg,   tx_crc_next;

    logic              m_valid_reg,  m_valid_next;
    logic              m_kind_reg,   m_kind_next;
    logic [7:0]        m_byte_reg,   m_byte_next;
    logic              m_last_reg,   m_last_next;
    logic [2:0]        m_status_reg, m_status_next;
    logic [31:0]       m_rdata_reg,  m_rdata_next;

    logic              out_free;
    logic [1:0]        lenm1;
    logic [7:0]        len_byte;
    logic [IDX_W-1:0]  last_idx;
    logic [1:0]        data_sel;
    logic [7:0]        tx_byte;
    logic [7:0]        crc_rx;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  data_cnt;
    logic [CNT_W-1:0]  read_len;
    logic [31:0]       asm_shift;

    assign out_free = !m_valid_reg || m_tready;

    // Packet byte selection for the latched request
    always_comb begin
        case (req_reg.data_mode)
            2'd0:    lenm1 = 2'd0;
            2'd1:    lenm1 = 2'd1;
            default: lenm1 = 2'd3;
        endcase
        len_byte = {6'd0, lenm1} + 8'd1;
        last_idx = req_reg.is_write ? IDX_W'(HDR_BYTES) + {2'b00, lenm1}
                                    : IDX_W'(HDR_BYTES - 1);
        data_sel = lenm1 - idx_reg[1:0];
        case (idx_reg)
            4'd0:    tx_byte = req_reg.address[31:24];
            4'd1:    tx_byte = req_reg.address[23:16];
            4'd2:    tx_byte = req_reg.address[15:8];
            4'd3:    tx_byte = req_reg.address[7:0];
            4'd4:    tx_byte = 8'h00;
            4'd5:    tx_byte = 8'h00;
            4'd6:    tx_byte = 8'h00;
            4'd7:    tx_byte = len_byte;
            4'd8:    tx_byte = {req_reg.is_write, 3'b000, req_reg.data_mode, req_reg.addr_mode};
            4'd9:    tx_byte = 8'h00;
            4'd10:   tx_byte = HDR_ID;
            4'd11:   tx_byte = tx_crc_reg;
            default: tx_byte = req_reg.write_data[{data_sel, 3'b000} +: 8];
        endcase
    end

    // Receive path helpers
    always_comb begin
        crc_rx    = crc8_byte(rx_crc_reg, q_job.rx_byte);
        cnt_inc   = rx_count_reg + 1'b1;
        data_cnt  = cnt_inc - CNT_W'(HDR_BYTES);
        asm_shift = {read_asm_reg[23:0], q_job.rx_byte};
        case (size_reg)
            2'd0:    read_len = CNT_W'(1);
            2'd1:    read_len = CNT_W'(2);
            default: read_len = CNT_W'(4);
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next    = state_reg;
        pending_next  = pending_reg;
        is_read_next  = is_read_reg;
        size_next     = size_reg;
        rx_count_next = rx_count_reg;
        rx_crc_next   = rx_crc_reg;
        ack_mode_next = ack_mode_reg;
        read_asm_next = read_asm_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        tx_crc_next   = tx_crc_reg;
        pop           = 1'b0;

        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;
        m_rdata_next  = m_rdata_reg;

        case (state_reg)
            S_IDLE: begin
                if (q_valid && out_free) begin
                    pop = 1'b1;
                    case (q_job.op)
                        OP_BAD_MODE: begin
                            pending_next  = 1'b0;
                            rx_count_next = '0;
                            rx_crc_next   = CRC_INIT;
                            m_valid_next  = 1'b1;
                            m_kind_next   = RK_DONE;
                            m_byte_next   = 8'h00;
                            m_last_next   = 1'b0;
                            m_status_next = STAT_BAD_MODE;
                            m_rdata_next  = '0;
                        end
                        OP_REQUEST: begin
                            pending_next  = 1'b1;
                            rx_count_next = '0;
                            rx_crc_next   = CRC_INIT;
                            is_read_next  = !q_job.is_write;
                            size_next     = q_job.data_mode;
                            ack_mode_next = '0;
                            read_asm_next = '0;
                            req_next      = q_job;
                            idx_next      = '0;
                            tx_crc_next   = CRC_INIT;
                            state_next    = S_SEND;
                        end
                        OP_RX_BYTE: begin
                            if (pending_reg) begin
                                rx_count_next = cnt_inc;
                                if (rx_count_reg < CNT_W'(HDR_BYTES)) begin
                                    // header byte
                                    rx_crc_next = crc_rx;
                                    if (rx_count_reg == CNT_W'(8)) begin
                                        ack_mode_next[15:8] = q_job.rx_byte;
                                    end else if (rx_count_reg == CNT_W'(9)) begin
                                        ack_mode_next[7:0] = q_job.rx_byte;
                                    end
                                    if (cnt_inc == CNT_W'(HDR_BYTES)) begin
                                        m_kind_next  = RK_DONE;
                                        m_byte_next  = 8'h00;
                                        m_last_next  = 1'b0;
                                        m_rdata_next = '0;
                                        if (crc_rx != 8'h00) begin
                                            m_valid_next  = 1'b1;
                                            m_status_next = STAT_CRC_ERR;
                                        end else if (ack_mode_reg[ACK_PARAM_BIT]) begin
                                            m_valid_next  = 1'b1;
                                            m_status_next = STAT_PARAM_ERR;
                                        end else if (ack_mode_reg[ACK_TIMEOUT_BIT]) begin
                                            m_valid_next  = 1'b1;
                                            m_status_next = STAT_TIMEOUT;
                                        end else if (!is_read_reg) begin
                                            m_valid_next  = 1'b1;
                                            m_status_next = STAT_OK;
                                        end else begin
                                            read_asm_next = '0;
                                        end
                                        if (crc_rx != 8'h00 || ack_mode_reg[ACK_PARAM_BIT]
                                            || ack_mode_reg[ACK_TIMEOUT_BIT] || !is_read_reg) begin
                                            pending_next  = 1'b0;
                                            rx_count_next = '0;
                                            rx_crc_next   = CRC_INIT;
                                        end
                                    end
                                end else begin
                                    // read data byte
                                    read_asm_next = asm_shift;
                                    if (data_cnt >= read_len) begin
                                        pending_next  = 1'b0;
                                        rx_count_next = '0;
                                        rx_crc_next   = CRC_INIT;
                                        m_valid_next  = 1'b1;
                                        m_kind_next   = RK_DONE;
                                        m_byte_next   = 8'h00;
                                        m_last_next   = 1'b0;
                                        m_status_next = STAT_OK;
                                        m_rdata_next  = asm_shift;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SEND: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_kind_next   = RK_TX;
                    m_byte_next   = tx_byte;
                    m_last_next   = (idx_reg == last_idx);
                    m_status_next = STAT_OK;
                    m_rdata_next  = '0;
                    tx_crc_next   = crc8_byte(tx_crc_reg, tx_byte);
                    idx_next      = idx_reg + 1'b1;
                    if (idx_reg == last_idx) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pending_reg  <= 1'b0;
            is_read_reg  <= 1'b0;
            size_reg     <= '0;
            rx_count_reg <= '0;
            rx_crc_reg   <= CRC_INIT;
            ack_mode_reg <= '0;
            read_asm_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            is_read_reg  <= is_read_next;
            size_reg     <= size_next;
            rx_count_reg <= rx_count_next;
            rx_crc_reg   <= rx_crc_next;
            ack_mode_reg <= ack_mode_next;
            read_asm_reg <= read_asm_next;
            m_valid_reg  <= m_valid_next;
        end
        req_reg      <= req_next;
        idx_reg      <= idx_next;
        tx_crc_reg   <= tx_crc_next;
        m_kind_reg   <= m_kind_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
        m_rdata_reg  <= m_rdata_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {5'd0, m_rdata_reg, m_status_reg, m_byte_reg};

endmodule

`default_nettype wire
